// ===== src/ppr_pkg.sv =====
// ---------------------------------------------------------------------------
// ppr_pkg
// Types and constants shared by the video register port and its testbench.
// ---------------------------------------------------------------------------
`default_nettype none

package ppr_pkg;

  // Depth of the sprite attribute store.
  localparam int SPRITE_DEPTH_DEFAULT = 256;

  // Item kinds.
  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_STATUS = 2'd2,
    CMD_DMA    = 2'd3
  } cmd_e;

  // Chip registers, selected by the low address bits below the I/O area.
  localparam logic [2:0] REG_CONTROL   = 3'd0;
  localparam logic [2:0] REG_MASK      = 3'd1;
  localparam logic [2:0] REG_STATUS    = 3'd2;
  localparam logic [2:0] REG_OAM_ADDR  = 3'd3;
  localparam logic [2:0] REG_OAM_DATA  = 3'd4;
  localparam logic [2:0] REG_SCROLL    = 3'd5;
  localparam logic [2:0] REG_ADDR      = 3'd6;
  localparam logic [2:0] REG_DATA      = 3'd7;

  // Full-width I/O addresses.
  localparam logic [15:0] ADDR_DMA_PAGE = 16'h4014;
  localparam logic [15:0] ADDR_PAD      = 16'h4016;

  // Masks on the 15-bit temporary address.
  localparam logic [14:0] T_KEEP_NT      = 15'h73ff;
  localparam logic [14:0] T_KEEP_SCROLL2 = 15'h0c1f;
  localparam logic [14:0] T_KEEP_SCROLL1 = 15'h7fe0;
  localparam logic [14:0] T_KEEP_ADDR2   = 15'h7f00;
  localparam logic [14:0] T_KEEP_ADDR1   = 15'h00ff;

  // Pointer steps for data access.
  localparam logic [14:0] STEP_ROW = 15'd32;
  localparam logic [14:0] STEP_ONE = 15'd1;

  // Palette area starts where bits 13:8 of the pointer are all ones.
  localparam logic [5:0] PALETTE_PAGE = 6'h3f;

  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
    logic [7:0]  vram_read_data;
    logic [7:0]  vram_mirror_read_data;
    logic [7:0]  buttons;
    logic [7:0]  dma_index;
    logic [7:0]  dma_byte;
    logic        dma_last;
  } item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        nmi_pulse;
    logic [14:0] vram_address;
    logic        vram_write_enable;
    logic        dma_requested;
    logic [7:0]  dma_page;
  } result_t;

endpackage

`default_nettype wire

// ===== src/ppr_ram.sv =====
// ---------------------------------------------------------------------------
// ppr_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module ppr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== src/ppu_register_port.sv =====
// ---------------------------------------------------------------------------
// ppu_register_port
// CPU-side register port of a tile video chip with a game-pad shift register.
// ---------------------------------------------------------------------------
// Usage:
//   The item channel (item_valid / item_stall / item) carries one transaction
//   per bus read, bus write, renderer status update or sprite DMA byte. The
//   result channel (result_valid / result_stall / result) returns exactly one
//   transaction per item, in order.
//   The register file updates at the accepting edge of an item and issues the
//   sprite RAM read; stage one then picks up the RAM data and pushes the result
//   into a two-entry output queue, which raises result_valid. Throughput is one
//   item per clock as long as results are taken.
//   The sprite store sits in a single-port-write, registered-read RAM; reads
//   and writes of it by successive items never collide because each item
//   touches it only once and the write lands before the next read.
//   When the receiver stalls, the queue and the stage in flight absorb up to
//   two results; item_stall rises only once both slots are committed and no
//   result leaves in that cycle.
//   Reset (rst, synchronous) holds item_stall high, clears all registers, sets
//   the pad status to all ones and empties the pipeline. The sprite RAM is not
//   cleared; reading an entry never written returns undefined data.
// ---------------------------------------------------------------------------
`default_nettype none

module ppu_register_port #(
  parameter int SPRITE_DEPTH = ppr_pkg::SPRITE_DEPTH_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_stall,
  input  wire ppr_pkg::item_t   item,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output ppr_pkg::result_t      result
);

  import ppr_pkg::*;

  localparam int AW = $clog2(SPRITE_DEPTH);

  // Architectural registers.
  logic [7:0]  control_reg, control_reg_next;
  logic [7:0]  status_reg, status_reg_next;
  logic [7:0]  sprite_address, sprite_address_next;
  logic [14:0] temp_address, temp_address_next;
  logic [14:0] vram_pointer, vram_pointer_next;
  logic        write_toggle, write_toggle_next;
  logic [7:0]  read_buffer, read_buffer_next;
  logic [7:0]  pad_status, pad_status_next;
  logic [7:0]  pad_shift, pad_shift_next;
  logic        dma_pending, dma_pending_next;
  logic [7:0]  dma_page_reg, dma_page_reg_next;

  // Sprite RAM port.
  logic          ram_wr_en;
  logic [AW-1:0] ram_wr_addr;
  logic [7:0]    ram_wr_data;
  logic          ram_rd_en;
  logic [7:0]    ram_rd_data;

  // Stage one: result waiting for the RAM data.
  logic    s1_valid;
  logic    s1_sprite_read;
  result_t s1_result;
  result_t s1_result_next;
  logic    sprite_read;

  // Output queue.
  result_t     q [2];
  logic        q_rd_ptr;
  logic        q_wr_ptr;
  logic [1:0]  q_count;
  logic [2:0]  occupancy;
  logic        push;
  logic        pop;
  logic        accept;
  result_t     push_result;

  // Address decode.
  logic        low_area;
  logic [14:0] pointer_step;
  logic [14:0] pointer_advanced;
  logic        palette_hit;

  assign low_area         = (item.bus_address[15:14] == 2'b00);
  assign pointer_step     = control_reg[2] ? STEP_ROW : STEP_ONE;
  assign pointer_advanced = vram_pointer + pointer_step;
  assign palette_hit      = (vram_pointer[13:8] == PALETTE_PAGE);

  // Handshake: accept while a slot is free or one leaves this cycle; hold
  // off the sender during reset.
  assign pop        = result_valid && !result_stall;
  assign push       = s1_valid;
  assign occupancy  = {1'b0, q_count} + {2'b00, s1_valid};
  assign item_stall = rst || !((occupancy < 3'd2) || ((occupancy == 3'd2) && pop));
  assign accept     = item_valid && !item_stall;

  // Register update and result for the item at the input.
  always_comb begin
    control_reg_next    = control_reg;
    status_reg_next     = status_reg;
    sprite_address_next = sprite_address;
    temp_address_next   = temp_address;
    vram_pointer_next   = vram_pointer;
    write_toggle_next   = write_toggle;
    read_buffer_next    = read_buffer;
    pad_status_next     = pad_status;
    pad_shift_next      = pad_shift;
    dma_pending_next    = dma_pending;
    dma_page_reg_next   = dma_page_reg;
    ram_wr_en           = 1'b0;
    ram_wr_addr         = sprite_address[AW-1:0];
    ram_wr_data         = item.write_data;
    sprite_read         = 1'b0;
    s1_result_next      = '0;

    case (item.cmd)
      CMD_READ: begin
        if (low_area && item.bus_address[2:0] == REG_STATUS) begin
          write_toggle_next        = 1'b0;
          s1_result_next.read_data = status_reg;
          status_reg_next          = {1'b0, status_reg[6:0]};
        end else if (low_area && item.bus_address[2:0] == REG_OAM_DATA) begin
          sprite_read = 1'b1;
        end else if (low_area && item.bus_address[2:0] == REG_DATA) begin
          s1_result_next.vram_address = vram_pointer;
          if (palette_hit) begin
            read_buffer_next         = item.vram_mirror_read_data;
            s1_result_next.read_data = item.vram_read_data;
          end else begin
            read_buffer_next         = item.vram_read_data;
            s1_result_next.read_data = read_buffer;
          end
          vram_pointer_next = pointer_advanced;
        end else if (item.bus_address == ADDR_PAD) begin
          pad_status_next          = {pad_status[7:1], pad_shift[0]};
          pad_shift_next           = {1'b1, pad_shift[7:1]};
          s1_result_next.read_data = {pad_status[7:1], pad_shift[0]};
        end
      end
      CMD_WRITE: begin
        if (low_area && item.bus_address[2:0] == REG_CONTROL) begin
          s1_result_next.nmi_pulse = status_reg[7] && item.write_data[7]
                                     && !control_reg[7];
          control_reg_next  = item.write_data;
          temp_address_next = (temp_address & T_KEEP_NT)
                              | {3'b000, item.write_data[1:0], 10'd0};
        end else if (low_area && item.bus_address[2:0] == REG_OAM_ADDR) begin
          sprite_address_next = item.write_data;
        end else if (low_area && item.bus_address[2:0] == REG_OAM_DATA) begin
          ram_wr_en           = 1'b1;
          sprite_address_next = sprite_address + 8'd1;
        end else if (low_area && item.bus_address[2:0] == REG_SCROLL) begin
          if (write_toggle) begin
            temp_address_next = (temp_address & T_KEEP_SCROLL2)
                                | {item.write_data[2:0], 2'b00,
                                   item.write_data[7:3], 5'd0};
          end else begin
            temp_address_next = (temp_address & T_KEEP_SCROLL1)
                                | {10'd0, item.write_data[7:3]};
          end
          write_toggle_next = !write_toggle;
        end else if (low_area && item.bus_address[2:0] == REG_ADDR) begin
          if (write_toggle) begin
            temp_address_next = (temp_address & T_KEEP_ADDR2)
                                | {7'd0, item.write_data};
            vram_pointer_next = (temp_address & T_KEEP_ADDR2)
                                | {7'd0, item.write_data};
          end else begin
            temp_address_next = (temp_address & T_KEEP_ADDR1)
                                | {1'b0, item.write_data[5:0], 8'd0};
          end
          write_toggle_next = !write_toggle;
        end else if (low_area && item.bus_address[2:0] == REG_DATA) begin
          s1_result_next.vram_address      = vram_pointer;
          s1_result_next.vram_write_enable = 1'b1;
          vram_pointer_next                = pointer_advanced;
        end else if (item.bus_address == ADDR_DMA_PAGE) begin
          dma_page_reg_next = item.write_data;
          dma_pending_next  = 1'b1;
        end else if (item.bus_address == ADDR_PAD) begin
          if (pad_status[0] && !item.write_data[0]) begin
            pad_shift_next = item.buttons;
          end
          pad_status_next = item.write_data;
        end
      end
      CMD_STATUS: begin
        status_reg_next = item.write_data;
      end
      CMD_DMA: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = item.dma_index[AW-1:0];
        ram_wr_data = item.dma_byte;
        if (item.dma_last) begin
          dma_pending_next = 1'b0;
        end
      end
      default: begin
      end
    endcase

    s1_result_next.dma_requested = dma_pending_next;
    s1_result_next.dma_page      = dma_page_reg_next;
  end

  assign ram_rd_en = accept && sprite_read;

  // Commit register state on each accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      control_reg    <= '0;
      status_reg     <= '0;
      sprite_address <= '0;
      temp_address   <= '0;
      vram_pointer   <= '0;
      write_toggle   <= 1'b0;
      read_buffer    <= '0;
      pad_status     <= 8'hff;
      pad_shift      <= '0;
      dma_pending    <= 1'b0;
      dma_page_reg   <= '0;
    end else if (accept) begin
      control_reg    <= control_reg_next;
      status_reg     <= status_reg_next;
      sprite_address <= sprite_address_next;
      temp_address   <= temp_address_next;
      vram_pointer   <= vram_pointer_next;
      write_toggle   <= write_toggle_next;
      read_buffer    <= read_buffer_next;
      pad_status     <= pad_status_next;
      pad_shift      <= pad_shift_next;
      dma_pending    <= dma_pending_next;
      dma_page_reg   <= dma_page_reg_next;
    end
  end

  // Sprite attribute store.
  ppr_ram #(
    .WIDTH (8),
    .DEPTH (SPRITE_DEPTH)
  ) u_sprite_ram (
    .clk     (clk),
    .wr_en   (accept && ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (sprite_address[AW-1:0]),
    .rd_data (ram_rd_data)
  );

  // Stage one: hold the result until the RAM data is back.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_result      <= s1_result_next;
      s1_sprite_read <= sprite_read;
    end
  end

  // Merge the sprite byte into the result on its way to the queue.
  always_comb begin
    push_result = s1_result;
    if (s1_sprite_read) begin
      push_result.read_data = ram_rd_data;
    end
  end

  // Output queue: two entries, advanced by push and pop.
  always_ff @(posedge clk) begin
    if (rst) begin
      q_rd_ptr <= 1'b0;
      q_wr_ptr <= 1'b0;
      q_count  <= '0;
    end else begin
      if (push) begin
        q_wr_ptr <= !q_wr_ptr;
      end
      if (pop) begin
        q_rd_ptr <= !q_rd_ptr;
      end
      q_count <= q_count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[q_wr_ptr] <= push_result;
    end
  end

  assign result_valid = (q_count != 2'd0);
  assign result       = q[q_rd_ptr];

  // Checks.
  a_queue_bound : assert property (@(posedge clk) disable iff (rst)
    q_count <= 2'd2)
    else $error("output queue overflow");

  a_accept_room : assert property (@(posedge clk) disable iff (rst)
    accept |-> ((occupancy < 3'd2) || pop))
    else $error("item accepted without room for its result");

  a_status_read_toggle : assert property (@(posedge clk) disable iff (rst)
    (accept && item.cmd == CMD_READ && low_area
     && item.bus_address[2:0] == REG_STATUS) |=> !write_toggle)
    else $error("status read did not clear the write toggle");

  a_write_no_data : assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.vram_write_enable) |-> (result.read_data == 8'd0))
    else $error("video write result carries read data");

endmodule

`default_nettype wire

// ===== sim/tb_ppu_register_port.sv =====
// ---------------------------------------------------------------------------
// tb_ppu_register_port
// Self-checking bench for the video register port and pad shift register.
// Bus reads, bus writes, status updates and sprite DMA bytes go into the
// block. A register-level tracker predicts every reply and compares it
// against the result channel in order, under random idle and stall traffic.
// ---------------------------------------------------------------------------
`default_nettype none

import ppr_pkg::*;

class ppu_reg_tracker;
  logic [7:0]  ctrl, mask, status, oam_addr, read_buf, pad_status, pad_shift, page;
  logic [14:0] t_addr, vptr;
  logic [2:0]  fine_x;
  logic        toggle, pending;
  logic [7:0]  sprite_ram [SPRITE_DEPTH_DEFAULT];
  bit          sprite_valid [SPRITE_DEPTH_DEFAULT];
  result_t     replies_due [$];
  int          errors;

  function new();
    ctrl = '0; mask = '0; status = '0; oam_addr = '0; read_buf = '0;
    pad_status = 8'hff; pad_shift = '0; page = '0;
    t_addr = '0; vptr = '0; fine_x = '0; toggle = 1'b0; pending = 1'b0;
    errors = 0;
    foreach (sprite_valid[i]) sprite_valid[i] = 1'b0;
  endfunction

  function bit oam_entry_written();
    return sprite_valid[oam_addr];
  endfunction

  function void step_pointer();
    vptr = vptr + (ctrl[2] ? STEP_ROW : STEP_ONE);
  endfunction

  // Apply one accepted transaction and queue the reply it must produce.
  function void take_access(item_t it);
    logic [15:0] a;
    logic [7:0]  wd;
    result_t     r;
    r  = '0;
    wd = it.write_data;
    a  = it.bus_address;
    if (a < 16'h4000) a = {13'd0, a[2:0]};
    case (it.cmd)
      CMD_READ: begin
        if (a == REG_STATUS) begin
          toggle = 1'b0;
          r.read_data = status;
          status[7] = 1'b0;
        end else if (a == REG_OAM_DATA) begin
          r.read_data = sprite_ram[oam_addr];
        end else if (a == REG_DATA) begin
          r.vram_address = vptr;
          if (vptr[13:8] == PALETTE_PAGE) begin
            r.read_data = it.vram_read_data;
            read_buf = it.vram_mirror_read_data;
          end else begin
            r.read_data = read_buf;
            read_buf = it.vram_read_data;
          end
          step_pointer();
        end else if (a == ADDR_PAD) begin
          pad_status = {pad_status[7:1], pad_shift[0]};
          pad_shift = {1'b1, pad_shift[7:1]};
          r.read_data = pad_status;
        end
      end
      CMD_WRITE: begin
        if (a == REG_CONTROL) begin
          r.nmi_pulse = status[7] && wd[7] && !ctrl[7];
          ctrl = wd;
          t_addr = (t_addr & T_KEEP_NT) | {3'd0, wd[1:0], 10'd0};
        end else if (a == REG_MASK) begin
          mask = wd;
        end else if (a == REG_OAM_ADDR) begin
          oam_addr = wd;
        end else if (a == REG_OAM_DATA) begin
          sprite_ram[oam_addr] = wd;
          sprite_valid[oam_addr] = 1'b1;
          oam_addr = oam_addr + 8'd1;
        end else if (a == REG_SCROLL) begin
          if (toggle) begin
            t_addr = (t_addr & T_KEEP_SCROLL2) | {wd[2:0], 12'd0} | {5'd0, wd[7:3], 5'd0};
          end else begin
            t_addr = (t_addr & T_KEEP_SCROLL1) | {10'd0, wd[7:3]};
            fine_x = wd[2:0];
          end
          toggle = !toggle;
        end else if (a == REG_ADDR) begin
          if (toggle) begin
            t_addr = (t_addr & T_KEEP_ADDR2) | {7'd0, wd};
            vptr = t_addr;
          end else begin
            t_addr = (t_addr & T_KEEP_ADDR1) | {1'b0, wd[5:0], 8'd0};
          end
          toggle = !toggle;
        end else if (a == REG_DATA) begin
          r.vram_address = vptr;
          r.vram_write_enable = 1'b1;
          step_pointer();
        end else if (a == ADDR_DMA_PAGE) begin
          page = wd;
          pending = 1'b1;
        end else if (a == ADDR_PAD) begin
          if (pad_status[0] && !wd[0]) pad_shift = it.buttons;
          pad_status = wd;
        end
      end
      CMD_STATUS: status = wd;
      CMD_DMA: begin
        sprite_ram[it.dma_index] = it.dma_byte;
        sprite_valid[it.dma_index] = 1'b1;
        if (it.dma_last) pending = 1'b0;
      end
      default: begin
      end
    endcase
    r.dma_requested = pending;
    r.dma_page = page;
    replies_due.push_back(r);
  endfunction

  function void compare_field(string name, logic [14:0] want, logic [14:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  function void check_reply(result_t got);
    result_t want;
    if (replies_due.size() == 0) begin
      errors++;
      $display("%0t: result with nothing outstanding: expected none, actual %h", $time, got);
      return;
    end
    want = replies_due.pop_front();
    compare_field("read_data", 15'(want.read_data), 15'(got.read_data));
    compare_field("nmi_pulse", 15'(want.nmi_pulse), 15'(got.nmi_pulse));
    compare_field("vram_address", want.vram_address, got.vram_address);
    compare_field("vram_write_enable", 15'(want.vram_write_enable),
                  15'(got.vram_write_enable));
    compare_field("dma_requested", 15'(want.dma_requested), 15'(got.dma_requested));
    compare_field("dma_page", 15'(want.dma_page), 15'(got.dma_page));
  endfunction
endclass

module tb_ppu_register_port;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 1550;

  logic    clk = 1'b0;
  logic    rst;
  logic    item_valid;
  logic    item_stall;
  item_t   item;
  logic    result_valid;
  logic    result_stall;
  result_t result;

  int sender_idle_pct;
  int stall_pct;
  int items_sent;
  int cycle_count;
  ppu_reg_tracker tracker;

  ppu_register_port dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: check each transaction taken at this edge (pre-edge values),
  // then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) tracker.check_reply(result);
    result_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Every field random; callers override what the transaction needs.
  function automatic item_t random_item();
    item_t it;
    it.cmd                   = cmd_e'($urandom_range(0, 3));
    it.bus_address           = 16'($urandom);
    it.write_data            = 8'($urandom);
    it.vram_read_data        = 8'($urandom);
    it.vram_mirror_read_data = 8'($urandom);
    it.buttons               = 8'($urandom);
    it.dma_index             = 8'($urandom);
    it.dma_byte              = 8'($urandom);
    it.dma_last              = 1'($urandom);
    return it;
  endfunction

  // Chip register address with random mirror bits below the I/O area.
  function automatic logic [15:0] reg_addr(logic [2:0] r);
    return {2'b00, 11'($urandom), r};
  endfunction

  // Present one transaction, hold it until taken, then update the tracker.
  // Valid is only lowered when an idle cycle is chosen, so a back-to-back
  // transaction never sees valid dropped and raised in the same step.
  task automatic send_item(input item_t it);
    // Never read a sprite entry that has not been written: turn it into a write.
    if (it.cmd == CMD_READ && it.bus_address < 16'h4000 &&
        it.bus_address[2:0] == REG_OAM_DATA && !tracker.oam_entry_written())
      it.cmd = CMD_WRITE;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    tracker.take_access(it);
    items_sent++;
  endtask

  task automatic bus_write(input logic [15:0] addr, input logic [7:0] data);
    item_t it;
    it = random_item();
    it.cmd = CMD_WRITE;
    it.bus_address = addr;
    it.write_data = data;
    send_item(it);
  endtask

  task automatic bus_read(input logic [15:0] addr);
    item_t it;
    it = random_item();
    it.cmd = CMD_READ;
    it.bus_address = addr;
    send_item(it);
  endtask

  task automatic status_set(input logic [7:0] data);
    item_t it;
    it = random_item();
    it.cmd = CMD_STATUS;
    it.write_data = data;
    send_item(it);
  endtask

  task automatic dma_put(input logic [7:0] idx, input logic [7:0] data, input logic last);
    item_t it;
    it = random_item();
    it.cmd = CMD_DMA;
    it.dma_index = idx;
    it.dma_byte = data;
    it.dma_last = last;
    send_item(it);
  endtask

  // Hold off the sender until every outstanding reply has come back.
  task automatic drain();
    item_valid <= 1'b0;
    while (tracker.replies_due.size() != 0) @(posedge clk);
  endtask

  // One short burst of traffic the way software drives the port.
  task automatic run_sequence(input int kind);
    int n;
    int i;
    logic [7:0] b;
    n = $urandom_range(1, 8);
    case (kind)
      0, 1: send_item(random_item());
      2: begin
        // Set the address pointer, often into the palette, then walk data.
        bus_write(reg_addr(REG_ADDR), ($urandom_range(0, 2) == 0) ? 8'h3f : 8'($urandom));
        bus_write(reg_addr(REG_ADDR), 8'($urandom));
        repeat (n) begin
          if ($urandom_range(0, 1)) bus_read(reg_addr(REG_DATA));
          else bus_write(reg_addr(REG_DATA), 8'($urandom));
        end
      end
      3: begin
        bus_write(reg_addr(REG_SCROLL), 8'($urandom));
        if ($urandom_range(0, 3) == 0) bus_read(reg_addr(REG_STATUS));
        bus_write(reg_addr(REG_SCROLL), 8'($urandom));
      end
      4: begin
        // Vblank mostly set, then a control write that may raise NMI enable.
        status_set({1'($urandom_range(0, 3) != 0), 7'($urandom)});
        bus_write(reg_addr(REG_CONTROL), 8'($urandom));
        if ($urandom_range(0, 1)) bus_read(reg_addr(REG_STATUS));
      end
      5: begin
        // Strobe high then low latches the buttons; shift them out.
        bus_write(ADDR_PAD, {7'($urandom), 1'b1});
        bus_write(ADDR_PAD, {7'($urandom), 1'b0});
        repeat ($urandom_range(1, 10)) bus_read(ADDR_PAD);
      end
      6: begin
        b = 8'($urandom);
        bus_write(reg_addr(REG_OAM_ADDR), b);
        repeat ($urandom_range(1, 4)) bus_write(reg_addr(REG_OAM_DATA), 8'($urandom));
        bus_write(reg_addr(REG_OAM_ADDR), b);
        repeat ($urandom_range(1, 2)) bus_read(reg_addr(REG_OAM_DATA));
      end
      7: begin
        bus_write(ADDR_DMA_PAGE, 8'($urandom));
        for (i = 0; i < n; i++) dma_put(8'($urandom), 8'($urandom), i == n - 1);
      end
      8: begin
        bus_write(reg_addr(REG_CONTROL), 8'($urandom));
        bus_write(reg_addr(REG_MASK), 8'($urandom));
      end
      default: begin
        if ($urandom_range(0, 1)) bus_read(reg_addr(3'($urandom)));
        else bus_read(reg_addr(REG_STATUS));
      end
    endcase
  endtask

  initial begin
    tracker = new();
    rst          <= 1'b1;
    item_valid   <= 1'b0;
    item         <= '0;
    result_stall <= 1'b0;
    sender_idle_pct = 10;
    stall_pct = 52;
    items_sent = 0;
    cycle_count = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset values, unmapped decode, NMI edge, palette and
    // pointer wrap, sprite address wrap, DMA flag and pad latch.
    bus_read(16'h2002);
    bus_read(ADDR_PAD);
    bus_read(ADDR_DMA_PAGE);
    bus_read(16'hffff);
    bus_write(16'hffff, 8'hff);
    bus_write(reg_addr(REG_STATUS), 8'h00);
    status_set(8'h80);
    bus_write(16'h0000, 8'h80);
    bus_write(16'h2000, 8'h84);
    bus_write(16'h2000, 8'h00);
    bus_write(16'h3ff8, 8'hff);
    bus_write(reg_addr(REG_ADDR), 8'h3f);
    bus_write(reg_addr(REG_ADDR), 8'h00);
    bus_read(reg_addr(REG_DATA));
    bus_write(reg_addr(REG_ADDR), 8'hff);
    bus_write(reg_addr(REG_ADDR), 8'hff);
    bus_write(reg_addr(REG_DATA), 8'h5a);
    bus_read(reg_addr(REG_DATA));
    bus_write(reg_addr(REG_SCROLL), 8'hff);
    bus_write(reg_addr(REG_SCROLL), 8'h00);
    bus_write(reg_addr(REG_OAM_ADDR), 8'hff);
    bus_write(reg_addr(REG_OAM_DATA), 8'ha5);
    bus_write(reg_addr(REG_OAM_ADDR), 8'hff);
    bus_read(reg_addr(REG_OAM_DATA));
    bus_write(ADDR_DMA_PAGE, 8'hff);
    dma_put(8'h00, 8'hff, 1'b0);
    dma_put(8'hff, 8'h00, 1'b1);
    bus_write(ADDR_PAD, 8'h01);
    bus_write(ADDR_PAD, 8'h00);
    bus_read(ADDR_PAD);
    drain();

    // Random traffic in three phases: light sender idling with heavy
    // receiver stalls, then the reverse, then full rate both ways.
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent >= 1050 && sender_idle_pct != 0) begin
        drain();
        sender_idle_pct = 0;
        stall_pct = 0;
      end else if (items_sent >= 550 && sender_idle_pct == 10) begin
        drain();
        sender_idle_pct = 52;
        stall_pct = 10;
      end
      run_sequence($urandom_range(0, 9));
    end

    // Let the pipeline empty, then keep the clock running to catch strays.
    drain();
    repeat (10) @(posedge clk);
    if (tracker.errors == 0 && tracker.replies_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
